/* hdl/beacon_frequency_detector_core_assert.svh */
// Assertion macros shared by the checker modules of the beacon detector.
// Each macro expects signals named clk and rst_n in the calling scope.
`ifndef BEACON_FREQUENCY_DETECTOR_CORE_ASSERT_SVH
`define BEACON_FREQUENCY_DETECTOR_CORE_ASSERT_SVH

// Condition that must hold at every clock edge out of reset
`define BFD_CHECK(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Condition that must hold in the clock cycle after the trigger
`define BFD_CHECK_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

/* hdl/bfd_pkg.sv */
`default_nettype none

package bfd_pkg;

    // Field widths
    localparam int STAMP_W     = 32;
    localparam int HZ_W        = 24;
    localparam int BEACON_W    = 16;
    localparam int CONFIRM_W   = 8;
    localparam int WDOG_W      = 16;
    localparam int MODE_W      = 2;
    localparam int BEACON_COUNT = 4;
    localparam int BEACON_IDX_W = $clog2(BEACON_COUNT);

    // Configuration port
    localparam int CFG_DATA_W  = 24;
    localparam int CFG_INDEX_W = 3;

    // Smoothing: (new + 5*old) / 6, two quotient bits per cycle
    localparam int FIVE_W      = STAMP_W + 3;
    localparam int SUM_W       = STAMP_W + 4;
    localparam int DIV6_STEPS  = SUM_W / 2;
    localparam int DIV6_CNT_W  = $clog2(DIV6_STEPS);
    localparam int REM6_W      = 3;
    localparam int DIGIT6_W    = REM6_W + 2;
    localparam int SMOOTH_DIV  = 6;

    // Frequency divider: one quotient bit per cycle
    localparam int DIV_STEPS   = HZ_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    // Reset values of the configuration registers
    localparam logic [BEACON_W-1:0]  RST_BEACON0   = BEACON_W'(3333);
    localparam logic [BEACON_W-1:0]  RST_BEACON1   = BEACON_W'(1427);
    localparam logic [BEACON_W-1:0]  RST_BEACON2   = BEACON_W'(909);
    localparam logic [BEACON_W-1:0]  RST_BEACON3   = BEACON_W'(2000);
    localparam logic [BEACON_W-1:0]  RST_TOLERANCE = BEACON_W'(100);
    localparam logic [CONFIRM_W-1:0] RST_CONFIRM   = CONFIRM_W'(1);
    localparam logic [HZ_W-1:0]      RST_SCALE     = HZ_W'(1250000);
    localparam logic [WDOG_W-1:0]    RST_WATCHDOG  = WDOG_W'(50);

    // Command codes of an input word
    localparam logic CMD_EDGE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // Detector mode as reported on the result channel
    typedef enum logic [MODE_W-1:0] {
        MODE_IDLE = 2'd0,
        MODE_SEEN = 2'd1,
        MODE_LOCK = 2'd2
    } mode_t;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_BEACON0   = 3'd0,
        REG_BEACON1   = 3'd1,
        REG_BEACON2   = 3'd2,
        REG_BEACON3   = 3'd3,
        REG_TOLERANCE = 3'd4,
        REG_CONFIRM   = 3'd5,
        REG_SCALE     = 3'd6,
        REG_WATCHDOG  = 3'd7
    } cfg_reg_t;

    // Sequencer states of the top level
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_SUM,
        ST_DIV6,
        ST_FREQ,
        ST_FREQ_WAIT,
        ST_MATCH,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

/* hdl/bfd_if.sv */
`default_nettype none

// Input channel: edge events and watchdog ticks
interface bfd_item_if;
    import bfd_pkg::*;

    logic                valid;
    logic                ready;
    logic                command;
    logic [STAMP_W-1:0]  timestamp;

    modport source (output valid, output command, output timestamp, input ready);
    modport sink   (input valid, input command, input timestamp, output ready);
endinterface

// Result channel: one word per input word
interface bfd_result_if;
    import bfd_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [MODE_W-1:0]        mode;
    logic                     notify;
    logic [BEACON_IDX_W-1:0]  locked_index;
    logic [HZ_W-1:0]          frequency_hz;

    modport source (output valid, output mode, output notify, output locked_index,
                    output frequency_hz, input ready);
    modport sink   (input valid, input mode, input notify, input locked_index,
                    input frequency_hz, output ready);
endinterface

`default_nettype wire

/* hdl/bfd_serial_div.sv */
`default_nettype none

// Restoring divider, one quotient bit per cycle: scale / interval
module bfd_serial_div (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [bfd_pkg::HZ_W-1:0]     dividend,
    input  wire logic [bfd_pkg::STAMP_W-1:0]  divisor,
    output logic                              done,
    output logic [bfd_pkg::HZ_W-1:0]          quotient
);
    import bfd_pkg::*;

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [HZ_W-1:0]       work_reg, work_next;
    logic [STAMP_W-1:0]    rem_reg, rem_next;
    logic [STAMP_W-1:0]    divisor_reg, divisor_next;
    logic [STAMP_W:0]      trial;
    logic                  fits;

    // One trial subtraction per cycle
    always_comb
    begin
        trial        = {rem_reg, work_reg[HZ_W-1]};
        fits         = (trial >= {1'b0, divisor_reg});
        busy_next    = busy_reg;
        done_next    = 1'b0;
        cnt_next     = cnt_reg;
        work_next    = work_reg;
        rem_next     = rem_reg;
        divisor_next = divisor_reg;
        if (start)
        begin
            busy_next    = 1'b1;
            cnt_next     = '0;
            work_next    = dividend;
            rem_next     = '0;
            divisor_next = divisor;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? STAMP_W'(trial - {1'b0, divisor_reg}) : trial[STAMP_W-1:0];
            work_next = {work_reg[HZ_W-2:0], fits};
            cnt_next  = cnt_reg + DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath shift registers
    always_ff @(posedge clk)
    begin
        work_reg    <= work_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
    end

    assign done     = done_reg;
    assign quotient = work_reg;

endmodule

`default_nettype wire

/* hdl/beacon_frequency_detector_core.sv */
`default_nettype none

// Path from accepting a word to result valid: a tick or an edge in no signal goes from
// evaluation to the output register; the first interval adds the bit-serial frequency divide
// and up to 4 beacon compares, a later edge also the radix-4 smoothing divide.
// Throughput: one word in flight; the next is taken the cycle after the result enters
// the output register, which waits while the receiver holds a previous result.
// Reset (async, active low) clears to no signal and loads the default configuration.
module beacon_frequency_detector_core (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    bfd_item_if.sink                              item,
    bfd_result_if.source                          result,
    input  wire logic                             cfg_write,
    input  wire logic [bfd_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [bfd_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import bfd_pkg::*;

    localparam logic [DIGIT6_W-1:0] D6_1 = DIGIT6_W'(SMOOTH_DIV);
    localparam logic [DIGIT6_W-1:0] D6_2 = DIGIT6_W'(2 * SMOOTH_DIV);
    localparam logic [DIGIT6_W-1:0] D6_3 = DIGIT6_W'(3 * SMOOTH_DIV);

    // Configuration
    logic [BEACON_W-1:0]   beacon_reg [BEACON_COUNT];
    logic [BEACON_W-1:0]   tol_reg;
    logic [CONFIRM_W-1:0]  confirm_reg;
    logic [HZ_W-1:0]       scale_reg;
    logic [WDOG_W-1:0]     wdog_reg;

    // Sequencer and detector state
    state_t                   state_reg, state_next;
    logic                     cmd_reg, cmd_next;
    logic [STAMP_W-1:0]       stamp_reg, stamp_next;
    mode_t                    mode_reg, mode_next;
    logic [STAMP_W-1:0]       prev_reg, prev_next;
    logic                     prev_valid_reg, prev_valid_next;
    logic [STAMP_W-1:0]       avg_reg, avg_next;
    logic                     first_reg, first_next;
    logic [BEACON_IDX_W-1:0]  cand_reg, cand_next;
    logic                     cand_valid_reg, cand_valid_next;
    logic [CONFIRM_W-1:0]     repeat_reg, repeat_next;
    logic [BEACON_IDX_W-1:0]  lock_reg, lock_next;
    logic [WDOG_W-1:0]        idle_reg, idle_next;

    // Working registers
    logic [STAMP_W-1:0]       lapse_reg, lapse_next;
    logic [FIVE_W-1:0]        five_reg, five_next;
    logic [SUM_W-1:0]         sum_reg, sum_next;
    logic [REM6_W-1:0]        rem6_reg, rem6_next;
    logic [DIV6_CNT_W-1:0]    step_reg, step_next;
    logic [HZ_W-1:0]          hz_reg, hz_next;
    logic                     notify_reg, notify_next;
    logic [BEACON_IDX_W-1:0]  midx_reg, midx_next;

    // Output register
    logic                     out_valid_reg, out_valid_next;
    logic [MODE_W-1:0]        out_mode_reg, out_mode_next;
    logic                     out_notify_reg, out_notify_next;
    logic [BEACON_IDX_W-1:0]  out_lock_reg, out_lock_next;
    logic [HZ_W-1:0]          out_freq_reg, out_freq_next;

    // Combinational helpers
    logic                     div_start;
    logic                     div_done;
    logic [HZ_W-1:0]          div_quot;
    logic [WDOG_W-1:0]        idle_inc;
    logic [CONFIRM_W-1:0]     repeat_inc;
    logic [DIGIT6_W-1:0]      digit6;
    logic [1:0]               q6;
    logic [DIGIT6_W-1:0]      q6_sub;
    logic [BEACON_W-1:0]      beacon_sel;
    logic [BEACON_W-1:0]      win_lo;
    logic [BEACON_W:0]        win_hi;
    logic                     hit;

    bfd_serial_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (scale_reg),
        .divisor  (avg_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beacon_reg[0] <= RST_BEACON0;
            beacon_reg[1] <= RST_BEACON1;
            beacon_reg[2] <= RST_BEACON2;
            beacon_reg[3] <= RST_BEACON3;
            tol_reg       <= RST_TOLERANCE;
            confirm_reg   <= RST_CONFIRM;
            scale_reg     <= RST_SCALE;
            wdog_reg      <= RST_WATCHDOG;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_BEACON0:   beacon_reg[0] <= cfg_data[BEACON_W-1:0];
                REG_BEACON1:   beacon_reg[1] <= cfg_data[BEACON_W-1:0];
                REG_BEACON2:   beacon_reg[2] <= cfg_data[BEACON_W-1:0];
                REG_BEACON3:   beacon_reg[3] <= cfg_data[BEACON_W-1:0];
                REG_TOLERANCE: tol_reg       <= cfg_data[BEACON_W-1:0];
                REG_CONFIRM:   confirm_reg   <= cfg_data[CONFIRM_W-1:0];
                REG_SCALE:     scale_reg     <= cfg_data[HZ_W-1:0];
                REG_WATCHDOG:  wdog_reg      <= cfg_data[WDOG_W-1:0];
                default:       ;
            endcase
        end
    end

    // Saturating counters, smoothing digit and beacon window
    always_comb
    begin
        idle_inc   = (idle_reg == '1) ? idle_reg : idle_reg + WDOG_W'(1);
        repeat_inc = (repeat_reg == '1) ? repeat_reg : repeat_reg + CONFIRM_W'(1);

        digit6 = {rem6_reg, sum_reg[SUM_W-1 -: 2]};
        if (digit6 >= D6_3)
        begin
            q6 = 2'd3;
            q6_sub = D6_3;
        end
        else if (digit6 >= D6_2)
        begin
            q6 = 2'd2;
            q6_sub = D6_2;
        end
        else if (digit6 >= D6_1)
        begin
            q6 = 2'd1;
            q6_sub = D6_1;
        end
        else
        begin
            q6 = 2'd0;
            q6_sub = '0;
        end

        beacon_sel = beacon_reg[midx_reg];
        win_lo     = (beacon_sel > tol_reg) ? beacon_sel - tol_reg : '0;
        win_hi     = {1'b0, beacon_sel} + {1'b0, tol_reg};
        hit        = (hz_reg >= HZ_W'(win_lo)) && (hz_reg <= HZ_W'(win_hi));
    end

    // Next state and datapath
    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        stamp_next      = stamp_reg;
        mode_next       = mode_reg;
        prev_next       = prev_reg;
        prev_valid_next = prev_valid_reg;
        avg_next        = avg_reg;
        first_next      = first_reg;
        cand_next       = cand_reg;
        cand_valid_next = cand_valid_reg;
        repeat_next     = repeat_reg;
        lock_next       = lock_reg;
        idle_next       = idle_reg;
        lapse_next      = lapse_reg;
        five_next       = five_reg;
        sum_next        = sum_reg;
        rem6_next       = rem6_reg;
        step_next       = step_reg;
        hz_next         = hz_reg;
        notify_next     = notify_reg;
        midx_next       = midx_reg;
        out_valid_next  = out_valid_reg && !result.ready;
        out_mode_next   = out_mode_reg;
        out_notify_next = out_notify_reg;
        out_lock_next   = out_lock_reg;
        out_freq_next   = out_freq_reg;
        div_start       = 1'b0;
        item.ready      = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                item.ready = 1'b1;
                if (item.valid)
                begin
                    cmd_next   = item.command;
                    stamp_next = item.timestamp;
                    state_next = ST_EVAL;
                end
            end

            ST_EVAL:
            begin
                hz_next     = '0;
                notify_next = 1'b0;
                state_next  = ST_DONE;
                if (cmd_reg == CMD_TICK)
                begin
                    // Watchdog tick
                    if (mode_reg != MODE_IDLE)
                    begin
                        idle_next = idle_inc;
                        if (idle_inc >= wdog_reg)
                        begin
                            prev_valid_next = 1'b0;
                            avg_next        = '0;
                            first_next      = 1'b1;
                            cand_next       = '0;
                            cand_valid_next = 1'b0;
                            repeat_next     = '0;
                            lock_next       = '0;
                            mode_next       = MODE_IDLE;
                        end
                    end
                end
                else if (mode_reg == MODE_IDLE)
                begin
                    // First edge: restart history from this stamp
                    avg_next        = '0;
                    first_next      = 1'b1;
                    cand_next       = '0;
                    cand_valid_next = 1'b0;
                    repeat_next     = '0;
                    lock_next       = '0;
                    prev_next       = stamp_reg;
                    prev_valid_next = 1'b1;
                    idle_next       = '0;
                    mode_next       = MODE_SEEN;
                end
                else
                begin
                    if (mode_reg == MODE_SEEN)
                        idle_next = '0;
                    if (prev_valid_reg)
                    begin
                        lapse_next = stamp_reg - prev_reg;
                        five_next  = {1'b0, avg_reg, 2'b00} + FIVE_W'(avg_reg);
                        if (first_reg)
                        begin
                            avg_next   = stamp_reg - prev_reg;
                            first_next = 1'b0;
                            state_next = ST_FREQ;
                        end
                        else
                            state_next = ST_SUM;
                    end
                    prev_next       = stamp_reg;
                    prev_valid_next = 1'b1;
                end
            end

            ST_SUM:
            begin
                sum_next   = {1'b0, five_reg} + SUM_W'(lapse_reg);
                rem6_next  = '0;
                step_next  = '0;
                state_next = ST_DIV6;
            end

            ST_DIV6:
            begin
                // Shift out two dividend bits, shift in one quotient digit
                sum_next  = {sum_reg[SUM_W-3:0], q6};
                rem6_next = REM6_W'(digit6 - q6_sub);
                step_next = step_reg + DIV6_CNT_W'(1);
                if (step_reg == DIV6_CNT_W'(DIV6_STEPS - 1))
                begin
                    avg_next   = sum_next[STAMP_W-1:0];
                    state_next = ST_FREQ;
                end
            end

            ST_FREQ:
            begin
                if (avg_reg == '0)
                    state_next = ST_DONE;
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_FREQ_WAIT;
                end
            end

            ST_FREQ_WAIT:
            begin
                if (div_done)
                begin
                    hz_next   = div_quot;
                    midx_next = '0;
                    state_next = (div_quot == '0) ? ST_DONE : ST_MATCH;
                end
            end

            ST_MATCH:
            begin
                // One beacon per cycle, first match wins
                if (hit)
                begin
                    state_next = ST_DONE;
                    if (mode_reg == MODE_SEEN)
                    begin
                        if (cand_valid_reg && (midx_reg == cand_reg))
                        begin
                            repeat_next = repeat_inc;
                            if (repeat_inc >= confirm_reg)
                            begin
                                lock_next   = midx_reg;
                                notify_next = 1'b1;
                                mode_next   = MODE_LOCK;
                            end
                        end
                        else
                        begin
                            cand_next       = midx_reg;
                            cand_valid_next = 1'b1;
                            repeat_next     = CONFIRM_W'(1);
                        end
                    end
                    else
                    begin
                        idle_next = '0;
                        if (midx_reg != lock_reg)
                        begin
                            lock_next   = midx_reg;
                            notify_next = 1'b1;
                        end
                    end
                end
                else if (midx_reg == BEACON_IDX_W'(BEACON_COUNT - 1))
                begin
                    state_next = ST_DONE;
                    if (mode_reg == MODE_SEEN)
                    begin
                        cand_next       = '0;
                        cand_valid_next = 1'b0;
                        repeat_next     = '0;
                    end
                end
                else
                    midx_next = midx_reg + BEACON_IDX_W'(1);
            end

            ST_DONE:
            begin
                // Hand the word to the output register once it is free
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_mode_next   = mode_reg;
                    out_notify_next = notify_reg;
                    out_lock_next   = (mode_reg == MODE_LOCK) ? lock_reg : '0;
                    out_freq_next   = hz_reg;
                    state_next      = ST_IDLE;
                end
            end

            default:
                state_next = ST_IDLE;
        endcase
    end

    // Control and detector state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            mode_reg       <= MODE_IDLE;
            prev_reg       <= '0;
            prev_valid_reg <= 1'b0;
            avg_reg        <= '0;
            first_reg      <= 1'b1;
            cand_reg       <= '0;
            cand_valid_reg <= 1'b0;
            repeat_reg     <= '0;
            lock_reg       <= '0;
            idle_reg       <= '0;
            step_reg       <= '0;
            midx_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            mode_reg       <= mode_next;
            prev_reg       <= prev_next;
            prev_valid_reg <= prev_valid_next;
            avg_reg        <= avg_next;
            first_reg      <= first_next;
            cand_reg       <= cand_next;
            cand_valid_reg <= cand_valid_next;
            repeat_reg     <= repeat_next;
            lock_reg       <= lock_next;
            idle_reg       <= idle_next;
            step_reg       <= step_next;
            midx_reg       <= midx_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        stamp_reg      <= stamp_next;
        lapse_reg      <= lapse_next;
        five_reg       <= five_next;
        sum_reg        <= sum_next;
        rem6_reg       <= rem6_next;
        hz_reg         <= hz_next;
        notify_reg     <= notify_next;
        out_mode_reg   <= out_mode_next;
        out_notify_reg <= out_notify_next;
        out_lock_reg   <= out_lock_next;
        out_freq_reg   <= out_freq_next;
    end

    assign result.valid        = out_valid_reg;
    assign result.mode         = out_mode_reg;
    assign result.notify       = out_notify_reg;
    assign result.locked_index = out_lock_reg;
    assign result.frequency_hz = out_freq_reg;

endmodule

`default_nettype wire

/* hdl/bfd_checker.sv */
`default_nettype none

`include "beacon_frequency_detector_core_assert.svh"

// Port-level checks on the beacon detector
module bfd_checker (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              item_valid,
    input  wire logic                              item_ready,
    input  wire logic                              result_valid,
    input  wire logic                              result_ready,
    input  wire logic [bfd_pkg::MODE_W-1:0]        mode,
    input  wire logic                              notify,
    input  wire logic [bfd_pkg::BEACON_IDX_W-1:0]  locked_index,
    input  wire logic [bfd_pkg::HZ_W-1:0]          frequency_hz
);
    import bfd_pkg::*;

    // Hold a pending result word until it is taken
    `BFD_CHECK_NEXT(a_result_hold, result_valid && !result_ready, result_valid, "result word dropped")

    // A lock notice only comes with the locked mode
    `BFD_CHECK(a_notify_locked, !result_valid || !notify || (mode == MODE_LOCK), "notify without lock")

    // The locked index reads zero outside the locked mode
    `BFD_CHECK(a_index_zero, !result_valid || (locked_index == '0) || (mode == MODE_LOCK), "stray locked index")

    // A computed frequency never leaves the detector in no signal
    `BFD_CHECK(a_freq_mode, !result_valid || (frequency_hz == '0) || (mode != MODE_IDLE), "frequency in no signal")

    // One word at a time: drop ready right after an accept
    `BFD_CHECK_NEXT(a_one_word, item_valid && item_ready, !item_ready, "second word taken while busy")

endmodule

bind beacon_frequency_detector_core bfd_checker u_bfd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .mode         (result.mode),
    .notify       (result.notify),
    .locked_index (result.locked_index),
    .frequency_hz (result.frequency_hz)
);

`default_nettype wire

/* bench/beacon_detector_checker.sv */
module beacon_detector_checker (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    bfd_item_if                                   item,
    bfd_result_if                                 result,
    input  wire logic                             cfg_write,
    input  wire logic [bfd_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [bfd_pkg::CFG_DATA_W-1:0]   cfg_data,
    output int                                    mismatches,
    output int                                    awaited
);
    timeunit 1ns;
    timeprecision 1ps;

    import bfd_pkg::*;

    localparam logic [2:0] NO_BEACON = 3'd4;

    typedef struct packed {
        mode_t                    mode;
        logic                     notify;
        logic [BEACON_IDX_W-1:0]  locked_index;
        logic [HZ_W-1:0]          frequency_hz;
    } report_t;

    // Reports still owed by the block, oldest first
    report_t awaited_reports[$];

    // Register copy
    logic [BEACON_W-1:0]  beacon_freq [BEACON_COUNT];
    logic [BEACON_W-1:0]  tolerance;
    logic [CONFIRM_W-1:0] need_matches;
    logic [HZ_W-1:0]      scale;
    logic [WDOG_W-1:0]    tick_limit;

    // Detector state
    mode_t                    det_mode;
    logic [STAMP_W-1:0]       last_stamp;
    logic                     last_stamp_ok;
    logic [STAMP_W-1:0]       mean_lapse;
    logic                     mean_fresh;
    logic [BEACON_IDX_W-1:0]  cand_idx;
    logic                     cand_ok;
    logic [CONFIRM_W-1:0]     match_run;
    logic [BEACON_IDX_W-1:0]  lock_idx;
    logic [WDOG_W-1:0]        quiet_ticks;

    function automatic void forget_history();
        last_stamp_ok = 1'b0;
        mean_lapse    = '0;
        mean_fresh    = 1'b1;
        cand_idx      = '0;
        cand_ok       = 1'b0;
        match_run     = '0;
        lock_idx      = '0;
    endfunction

    // Fold one interval into the running mean and return the rate, 0 if none
    function automatic logic [31:0] fold_edge(logic [STAMP_W-1:0] stamp);
        logic [STAMP_W-1:0] lapse;
        logic [63:0]        blend;
        logic [31:0]        hz;
        hz = '0;
        if (last_stamp_ok)
        begin
            lapse = stamp - last_stamp;
            if (mean_fresh)
            begin
                mean_lapse = lapse;
                mean_fresh = 1'b0;
            end
            else
            begin
                blend      = 64'(lapse) + 64'(mean_lapse) * 64'd5;
                mean_lapse = 32'(blend / 64'd6);
            end
            if (mean_lapse != 0)
                hz = 32'(scale) / mean_lapse;
        end
        last_stamp    = stamp;
        last_stamp_ok = 1'b1;
        return hz;
    endfunction

    // First beacon whose window holds the rate; lower edge clamps at zero
    function automatic logic [2:0] match_beacon(logic [31:0] hz);
        logic [31:0] lo;
        logic [31:0] hi;
        for (int i = 0; i < BEACON_COUNT; i++)
        begin
            lo = (beacon_freq[i] > tolerance) ? 32'(beacon_freq[i] - tolerance) : 32'd0;
            hi = 32'(beacon_freq[i]) + 32'(tolerance);
            if (hz >= lo && hz <= hi)
                return 3'(i);
        end
        return NO_BEACON;
    endfunction

    function automatic report_t detector_step(logic cmd, logic [STAMP_W-1:0] stamp);
        report_t     rep;
        logic [31:0] hz;
        logic [2:0]  idx;
        logic        note;
        hz   = '0;
        note = 1'b0;
        if (cmd == CMD_EDGE)
        begin
            if (det_mode == MODE_IDLE)
            begin
                // First edge: restart history and latch the stamp
                forget_history();
                last_stamp    = stamp;
                last_stamp_ok = 1'b1;
                quiet_ticks   = '0;
                det_mode      = MODE_SEEN;
            end
            else if (det_mode == MODE_SEEN)
            begin
                quiet_ticks = '0;
                hz = fold_edge(stamp);
                if (hz != 0)
                begin
                    idx = match_beacon(hz);
                    if (idx != NO_BEACON)
                    begin
                        // Debounce on the same candidate, then lock
                        if (cand_ok && idx[1:0] == cand_idx)
                        begin
                            if (match_run != 8'hFF)
                                match_run++;
                            if (match_run >= need_matches)
                            begin
                                lock_idx = idx[1:0];
                                note     = 1'b1;
                                det_mode = MODE_LOCK;
                            end
                        end
                        else
                        begin
                            cand_idx  = idx[1:0];
                            cand_ok   = 1'b1;
                            match_run = 8'd1;
                        end
                    end
                    else
                    begin
                        cand_idx  = '0;
                        cand_ok   = 1'b0;
                        match_run = '0;
                    end
                end
            end
            else
            begin
                // Locked: only a matching rate kicks the watchdog
                hz = fold_edge(stamp);
                if (hz != 0)
                begin
                    idx = match_beacon(hz);
                    if (idx != NO_BEACON)
                    begin
                        quiet_ticks = '0;
                        if (idx[1:0] != lock_idx)
                        begin
                            lock_idx = idx[1:0];
                            note     = 1'b1;
                        end
                    end
                end
            end
        end
        else if (det_mode != MODE_IDLE)
        begin
            if (quiet_ticks != 16'hFFFF)
                quiet_ticks++;
            if (quiet_ticks >= tick_limit)
            begin
                forget_history();
                det_mode = MODE_IDLE;
            end
        end
        rep.mode         = det_mode;
        rep.notify       = note;
        rep.locked_index = (det_mode == MODE_LOCK) ? lock_idx : '0;
        rep.frequency_hz = hz[HZ_W-1:0];
        return rep;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        report_t want;
        if (!rst_n)
        begin
            beacon_freq[0] = RST_BEACON0;
            beacon_freq[1] = RST_BEACON1;
            beacon_freq[2] = RST_BEACON2;
            beacon_freq[3] = RST_BEACON3;
            tolerance      = RST_TOLERANCE;
            need_matches   = RST_CONFIRM;
            scale          = RST_SCALE;
            tick_limit     = RST_WATCHDOG;
            det_mode       = MODE_IDLE;
            last_stamp     = '0;
            quiet_ticks    = '0;
            forget_history();
            awaited_reports.delete();
            mismatches     = 0;
            awaited        = 0;
        end
        else
        begin
            // Compare a delivered word with the oldest owed report
            if (result.valid && result.ready)
            begin
                if (awaited_reports.size() == 0)
                begin
                    $error("result word with no edge or tick pending");
                    mismatches++;
                end
                else
                begin
                    want = awaited_reports.pop_front();
                    if (result.mode !== want.mode)
                    begin
                        $error("mode: expected %0d, got %0d", want.mode, result.mode);
                        mismatches++;
                    end
                    if (result.notify !== want.notify)
                    begin
                        $error("notify: expected %0d, got %0d", want.notify, result.notify);
                        mismatches++;
                    end
                    if (result.locked_index !== want.locked_index)
                    begin
                        $error("locked_index: expected %0d, got %0d",
                               want.locked_index, result.locked_index);
                        mismatches++;
                    end
                    if (result.frequency_hz !== want.frequency_hz)
                    begin
                        $error("frequency_hz: expected %0d, got %0d",
                               want.frequency_hz, result.frequency_hz);
                        mismatches++;
                    end
                end
            end

            // Advance the detector on each accepted word
            if (item.valid && item.ready)
                awaited_reports.push_back(detector_step(item.command, item.timestamp));

            // Track register writes
            if (cfg_write)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_BEACON0:   beacon_freq[0] = cfg_data[BEACON_W-1:0];
                    REG_BEACON1:   beacon_freq[1] = cfg_data[BEACON_W-1:0];
                    REG_BEACON2:   beacon_freq[2] = cfg_data[BEACON_W-1:0];
                    REG_BEACON3:   beacon_freq[3] = cfg_data[BEACON_W-1:0];
                    REG_TOLERANCE: tolerance      = cfg_data[BEACON_W-1:0];
                    REG_CONFIRM:   need_matches   = cfg_data[CONFIRM_W-1:0];
                    REG_SCALE:     scale          = cfg_data[HZ_W-1:0];
                    REG_WATCHDOG:  tick_limit     = cfg_data[WDOG_W-1:0];
                    default:       ;
                endcase
            end

            awaited = awaited_reports.size();
        end
    end

endmodule

/* bench/tb_beacon_frequency_detector_core.sv */
module tb_beacon_frequency_detector_core;
    timeunit 1ns;
    timeprecision 1ps;

    import bfd_pkg::*;

    localparam int STALL_LIMIT     = 4000;
    localparam int HOLD_OFF_CYCLES = 300;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_write;
    cfg_reg_t               cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    int                     mismatches;
    int                     awaited;

    // Register values as last written, used to aim the edge spacing
    logic [CFG_DATA_W-1:0]  setting [8];
    logic [STAMP_W-1:0]     stamp_now;
    int                     gap_pct;
    int                     stall_pct;
    logic                   hold_off_pending;
    int                     idle_cycles;

    bfd_item_if   item_ch ();
    bfd_result_if result_ch ();

    beacon_frequency_detector_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_ch),
        .result    (result_ch),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    beacon_detector_checker observer (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item_ch),
        .result     (result_ch),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .awaited    (awaited)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Offer one word, with an occasional gap first, and hold it until taken
    task automatic send_word(input logic cmd, input logic [STAMP_W-1:0] stamp);
        bit taken;
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
        begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        item_ch.valid     <= 1'b1;
        item_ch.command   <= cmd;
        item_ch.timestamp <= stamp;
        do
        begin
            @(negedge clk);
            taken = item_ch.ready;
            @(posedge clk);
        end while (!taken);
    endtask

    task automatic send_ticks(input int count);
        repeat (count) send_word(CMD_TICK, $urandom);
    endtask

    // Drop valid and wait until every owed report has been delivered
    task automatic drain();
        bit empty;
        item_ch.valid <= 1'b0;
        do
        begin
            @(negedge clk);
            empty = (awaited == 0);
            @(posedge clk);
        end while (!empty);
        repeat (8) @(posedge clk);
    endtask

    task automatic program_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_write     <= 1'b1;
        cfg_index     <= idx;
        cfg_data      <= value;
        setting[idx]   = value;
        @(posedge clk);
    endtask

    task automatic load_settings(input int b0, b1, b2, b3,
                                 input int tol, conf, scale, wd);
        program_reg(REG_BEACON0, CFG_DATA_W'(b0));
        program_reg(REG_BEACON1, CFG_DATA_W'(b1));
        program_reg(REG_BEACON2, CFG_DATA_W'(b2));
        program_reg(REG_BEACON3, CFG_DATA_W'(b3));
        program_reg(REG_TOLERANCE, CFG_DATA_W'(tol));
        program_reg(REG_CONFIRM, CFG_DATA_W'(conf));
        program_reg(REG_SCALE, CFG_DATA_W'(scale));
        program_reg(REG_WATCHDOG, CFG_DATA_W'(wd));
        cfg_write <= 1'b0;
    endtask

    // Edges spaced for one beacon with jitter inside its window, a few ticks mixed in
    task automatic send_sequence(input int beacon, input int count);
        longint hz;
        longint span;
        longint slack;
        longint lapse;
        hz   = longint'(setting[int'(REG_BEACON0) + beacon]);
        span = (hz != 0) ? longint'(setting[REG_SCALE]) / hz : 0;
        if (span == 0)
            span = $urandom_range(1, 2000);
        slack = (hz != 0) ? (longint'(setting[REG_TOLERANCE]) * span) / (4 * hz + 1)
                          : span / 8;
        if (slack > span / 4)
            slack = span / 4;
        repeat (count)
        begin
            if ($urandom_range(0, 6) == 0)
                send_word(CMD_TICK, $urandom);
            lapse     = span + longint'($urandom_range(0, 32'(2 * slack))) - slack;
            stamp_now = stamp_now + 32'(lapse);
            send_word(CMD_EDGE, stamp_now);
        end
    endtask

    // Mostly beacon-like edge runs; the rest tick bursts and stray edges
    task automatic run_random(input int edges);
        int sent;
        int pick;
        int wd;
        int run_cap;
        int len;
        wd      = int'(setting[REG_WATCHDOG]);
        run_cap = (int'(setting[REG_CONFIRM]) < 8) ? int'(setting[REG_CONFIRM]) : 8;
        sent    = 0;
        if (wd <= 60)
            send_ticks(wd);
        while (sent < edges)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
            begin
                len = $urandom_range(2, run_cap + 4);
                send_sequence($urandom_range(0, 3), len);
                sent += len;
            end
            else if (pick < 80)
            begin
                if (wd <= 60 && $urandom_range(0, 2) == 0)
                    send_ticks(wd + $urandom_range(0, 2));
                else
                    send_ticks($urandom_range(1, (wd < 5) ? wd : 5));
            end
            else
            begin
                // Stray edge: repeated stamp, short random lapse, or a jump anywhere
                pick = $urandom_range(0, 9);
                if (pick >= 2 && pick < 9)
                    stamp_now = stamp_now + $urandom_range(0, 20000);
                else if (pick == 9 && wd <= 60)
                    stamp_now = $urandom;
                send_word(CMD_EDGE, stamp_now);
                sent++;
                if (pick == 9 && wd <= 60)
                    send_ticks(wd);
            end
        end
    endtask

    // Receiver: random stalls, plus one long hold-off on request
    initial
    begin
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_off_pending)
            begin
                hold_off_pending = 1'b0;
                result_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                result_ch.ready <= 1'b1;
            end
            else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
            begin
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
                result_ch.ready <= 1'b1;
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    // Abort when no word moves for too long
    initial
    begin
        idle_cycles = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)
                || cfg_write)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("FAIL beacon_frequency_detector_core");
                $finish;
            end
        end
    end

    initial
    begin
        int tol_pick;
        rst_n               = 1'b0;
        cfg_write           = 1'b0;
        cfg_index           = REG_BEACON0;
        cfg_data            = '0;
        item_ch.valid       = 1'b0;
        item_ch.command     = CMD_EDGE;
        item_ch.timestamp   = '0;
        result_ch.ready     = 1'b0;
        hold_off_pending    = 1'b0;
        gap_pct             = 25;
        stall_pct           = 5;
        stamp_now           = '0;
        setting[REG_BEACON0]   = RST_BEACON0;
        setting[REG_BEACON1]   = RST_BEACON1;
        setting[REG_BEACON2]   = RST_BEACON2;
        setting[REG_BEACON3]   = RST_BEACON3;
        setting[REG_TOLERANCE] = RST_TOLERANCE;
        setting[REG_CONFIRM]   = RST_CONFIRM;
        setting[REG_SCALE]     = RST_SCALE;
        setting[REG_WATCHDOG]  = RST_WATCHDOG;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed run on reset values: tick in no signal, repeated stamp,
        // wrap, lock, re-lock on another beacon, intervals too long for a rate
        stamp_now = 32'hFFFF_FE00;
        send_word(CMD_TICK, 32'hFFFF_FFFF);
        send_word(CMD_EDGE, stamp_now);
        send_word(CMD_EDGE, stamp_now);
        stamp_now = stamp_now + 32'd2250;
        send_word(CMD_EDGE, stamp_now);
        stamp_now = stamp_now + 32'd375;
        send_word(CMD_EDGE, stamp_now);
        stamp_now = stamp_now + 32'd375;
        send_word(CMD_EDGE, stamp_now);
        send_word(CMD_TICK, 32'h0000_0000);
        stamp_now = stamp_now + 32'd1875;
        send_word(CMD_EDGE, stamp_now);
        stamp_now = stamp_now + 32'd625;
        send_word(CMD_EDGE, stamp_now);
        stamp_now = stamp_now + 32'h8000_0000;
        send_word(CMD_EDGE, stamp_now);
        send_word(CMD_EDGE, 32'hFFFF_FFFF);
        send_word(CMD_EDGE, 32'h0000_0000);
        send_word(CMD_TICK, 32'h5555_AAAA);
        send_word(CMD_EDGE, 32'h0000_0000);
        stamp_now = '0;

        run_random(30);
        drain();

        // Short watchdog, tight window, debounce of three; receiver holds off long
        gap_pct   = 40;
        stall_pct = 3;
        load_settings(500, 1000, 1500, 2500, 50, 3, 1250000, 4);
        hold_off_pending = 1'b1;
        run_random(40);
        send_ticks(int'(setting[REG_WATCHDOG]));
        drain();

        // Upper extremes: zero tolerance, long debounce, widest scale and watchdog
        gap_pct   = 10;
        stall_pct = 8;
        load_settings(65535, 0, 40000, 1000, 0, 40, 24'hFF_FFFF, 65535);
        send_sequence(3, 45);
        run_random(20);
        drain();

        // Lower extremes: unit scale, window covering everything, one-tick watchdog
        gap_pct   = 0;
        stall_pct = 0;
        load_settings(0, 1, 2, 65535, 65535, 1, 1, 1);
        run_random(30);
        drain();

        // Random settings, one beacon at or below its tolerance
        gap_pct   = 25;
        stall_pct = 5;
        tol_pick  = $urandom_range(0, 300);
        load_settings($urandom_range(0, 4000), $urandom_range(0, 4000),
                      $urandom_range(0, 4000), $urandom_range(0, tol_pick), tol_pick,
                      $urandom_range(1, 6), $urandom_range(200000, 16777215),
                      $urandom_range(1, 30));
        run_random(30);

        // Finish with no idling on either side
        gap_pct   = 0;
        stall_pct = 0;
        run_random(20);
        drain();
        repeat (60) @(posedge clk);

        if (mismatches == 0 && awaited == 0)
            $display("PASS beacon_frequency_detector_core");
        else
            $display("FAIL beacon_frequency_detector_core");
        $finish;
    end

endmodule
